### hdl/dsct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsct_pkg;

   localparam int unsigned FRAC_W  = 32;
   localparam int unsigned ANGLE_W = 64;
   localparam int unsigned VALUE_W = 34;
   localparam int unsigned WORD_W  = 33;
   localparam int unsigned DIFF_W  = 27;
   localparam int unsigned DEG_W   = 7;

   localparam logic [8:0] TURN_DEG    = 9'd360;
   localparam logic [8:0] THREE_Q_DEG = 9'd270;
   localparam logic [8:0] HALF_DEG    = 9'd180;
   localparam logic [8:0] QUARTER_DEG = 9'd90;

   // residues of byte weights of the integer part modulo 360
   localparam logic [16:0] BYTE2_RES = 17'd16;
   localparam logic [16:0] NEG_ADJ   = 17'd104;

   localparam logic [DEG_W-1:0] LAST_DEG = 7'd90;

   typedef struct packed {
      logic [DEG_W-1:0]  deg;
      logic [FRAC_W-1:0] frac;
      logic              neg;
   } fold_type;

   // sine of each whole degree scaled by 2^32
   function automatic logic [WORD_W-1:0] sine_word(input logic [DEG_W-1:0] d);
      logic [WORD_W-1:0] w;
      case (d)
         7'd0:  w = 33'd0;          7'd1:  w = 33'd74957514;   7'd2:  w = 33'd149892196;
         7'd3:  w = 33'd224781220;  7'd4:  w = 33'd299601773;  7'd5:  w = 33'd374331064;
         7'd6:  w = 33'd448946331;  7'd7:  w = 33'd523424844;  7'd8:  w = 33'd597743917;
         7'd9:  w = 33'd671880911;  7'd10: w = 33'd745813244;  7'd11: w = 33'd819518394;
         7'd12: w = 33'd892973912;  7'd13: w = 33'd966157421;  7'd14: w = 33'd1039046629;
         7'd15: w = 33'd1111619334; 7'd16: w = 33'd1183853428; 7'd17: w = 33'd1255726910;
         7'd18: w = 33'd1327217884; 7'd19: w = 33'd1398304576; 7'd20: w = 33'd1468965330;
         7'd21: w = 33'd1539178623; 7'd22: w = 33'd1608923067; 7'd23: w = 33'd1678177418;
         7'd24: w = 33'd1746920580; 7'd25: w = 33'd1815131612; 7'd26: w = 33'd1882789738;
         7'd27: w = 33'd1949874349; 7'd28: w = 33'd2016365008; 7'd29: w = 33'd2082241463;
         7'd30: w = 33'd2147483647; 7'd31: w = 33'd2212071687; 7'd32: w = 33'd2275985909;
         7'd33: w = 33'd2339206843; 7'd34: w = 33'd2401715232; 7'd35: w = 33'd2463492035;
         7'd36: w = 33'd2524518435; 7'd37: w = 33'd2584775842; 7'd38: w = 33'd2644245901;
         7'd39: w = 33'd2702910498; 7'd40: w = 33'd2760751761; 7'd41: w = 33'd2817752073;
         7'd42: w = 33'd2873894071; 7'd43: w = 33'd2929160652; 7'd44: w = 33'd2983534983;
         7'd45: w = 33'd3037000499; 7'd46: w = 33'd3089540917; 7'd47: w = 33'd3141140230;
         7'd48: w = 33'd3191782721; 7'd49: w = 33'd3241452965; 7'd50: w = 33'd3290135830;
         7'd51: w = 33'd3337816488; 7'd52: w = 33'd3384480415; 7'd53: w = 33'd3430113397;
         7'd54: w = 33'd3474701532; 7'd55: w = 33'd3518231240; 7'd56: w = 33'd3560689261;
         7'd57: w = 33'd3602062661; 7'd58: w = 33'd3642338838; 7'd59: w = 33'd3681505523;
         7'd60: w = 33'd3719550786; 7'd61: w = 33'd3756463038; 7'd62: w = 33'd3792231035;
         7'd63: w = 33'd3826843881; 7'd64: w = 33'd3860291034; 7'd65: w = 33'd3892562305;
         7'd66: w = 33'd3923647863; 7'd67: w = 33'd3953538241; 7'd68: w = 33'd3982224332;
         7'd69: w = 33'd4009697399; 7'd70: w = 33'd4035949074; 7'd71: w = 33'd4060971359;
         7'd72: w = 33'd4084756634; 7'd73: w = 33'd4107297651; 7'd74: w = 33'd4128587546;
         7'd75: w = 33'd4148619834; 7'd76: w = 33'd4167388411; 7'd77: w = 33'd4184887562;
         7'd78: w = 33'd4201111955; 7'd79: w = 33'd4216056649; 7'd80: w = 33'd4229717092;
         7'd81: w = 33'd4242089121; 7'd82: w = 33'd4253168969; 7'd83: w = 33'd4262953261;
         7'd84: w = 33'd4271439015; 7'd85: w = 33'd4278623648; 7'd86: w = 33'd4284504971;
         7'd87: w = 33'd4289081192; 7'd88: w = 33'd4292350917; 7'd89: w = 33'd4294313151;
         7'd90: w = 33'd4294967296;
         default: w = 33'd0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### hdl/dsct_fold.sv
`timescale 1ns / 1ps
`default_nettype none

module dsct_fold (
   input  wire logic [8:0]                 deg,
   input  wire logic [dsct_pkg::FRAC_W-1:0] frac,
   output dsct_pkg::fold_type              folded
);
   import dsct_pkg::*;

   logic [8:0]        d;
   logic [FRAC_W-1:0] f;
   logic              neg;
   logic              has_frac;

   assign has_frac = (frac != '0);

   always_comb begin
      d   = deg;
      f   = frac;
      neg = 1'b0;
      if (deg >= THREE_Q_DEG) begin
         neg = 1'b1;
         d   = TURN_DEG - deg;
         if (has_frac) begin
            d = d - 9'd1;
            f = ~frac + 32'd1;
         end
      end else if (deg >= HALF_DEG) begin
         neg = 1'b1;
         d   = deg - HALF_DEG;
      end else if (deg >= QUARTER_DEG) begin
         d = HALF_DEG - deg;
         if (has_frac) begin
            d = d - 9'd1;
            f = ~frac + 32'd1;
         end
      end
   end

   // folded degree never exceeds 90
   assign folded.deg  = d[DEG_W-1:0];
   assign folded.frac = f;
   assign folded.neg  = neg;

endmodule

`default_nettype wire

### hdl/degree_sine_cosine_table_interp.sv
`timescale 1ns / 1ps
`default_nettype none

// sine or cosine of an angle in degrees, table lookup with linear interpolation
// req channel: one word per angle, tdata the signed 32.32 angle, tuser 0 for
// sine and 1 for cosine
// rsp channel: one word per request, in order, the signed 2.32 result
// a new word is taken every cycle while the rsp side is not stalled; there are
// seven register stages: byte fold of the integer degrees,
// two stages of conditional subtracts of 360, cosine offset and quadrant fold,
// table read, 27x32 multiply, add and sign
// each stage has its own valid bit and moves when the stage after it is empty
// or moving, so a stalled rsp side lets empty stages fill before req_tready
// drops; nothing is lost or repeated
// reset clears the valid bits only; the datapath registers are not reset

module degree_sine_cosine_table_interp (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // angle[63:0]
   input  wire logic        req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // value[33:0], zero[39:34]
);
   import dsct_pkg::*;

   localparam int unsigned STAGES = 7;

   logic [STAGES:1] valid_ff, valid_in;
   logic [STAGES:1] stage_en;

   // stage 1: fold integer bytes into a small residue-equivalent sum
   logic [16:0]       s1_sum_ff, s1_sum_in;
   logic [FRAC_W-1:0] s1_frac_ff;
   logic              s1_func_ff;
   // stage 2, 3: subtract multiples of 360
   logic [12:0]       s2_sum_ff, s2_sum_in;
   logic [FRAC_W-1:0] s2_frac_ff;
   logic              s2_func_ff;
   logic [8:0]        s3_deg_ff, s3_deg_in;
   logic [FRAC_W-1:0] s3_frac_ff;
   logic              s3_func_ff;
   // stage 4: cosine offset and quadrant fold
   fold_type          s4_fold_ff, s4_fold_in;
   logic [9:0]        cos_sum;
   logic [8:0]        turn_deg;
   // stage 5: table read
   logic [WORD_W-1:0] s5_y0_ff, s5_y0_in;
   logic [DIFF_W-1:0] s5_diff_ff, s5_diff_in;
   logic [FRAC_W-1:0] s5_frac_ff;
   logic              s5_neg_ff;
   logic [WORD_W-1:0] y1_word, diff_full;
   // stage 6: multiply
   logic [DIFF_W-1:0] s6_step_ff, s6_step_in;
   logic [WORD_W-1:0] s6_y0_ff;
   logic              s6_neg_ff;
   logic [DIFF_W+FRAC_W-1:0] product;
   // stage 7: result
   logic [VALUE_W-1:0] s7_value_ff, s7_value_in;
   logic [VALUE_W-1:0] mag;

   always_comb begin
      stage_en[STAGES] = !valid_ff[STAGES] || rsp_tready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign req_tready = stage_en[1];

   always_comb begin
      valid_in[1] = req_tvalid;
      for (int k = 2; k <= STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   // stage 1 logic
   logic [7:0] b0, b1, b2, b3;
   assign {b3, b2, b1, b0} = req_tdata[63:32];

   // byte weights mod 360: 1, 256, 16, 136; negative word adds 360 - 256
   assign s1_sum_in = 17'(b0) + {1'b0, b1, 8'b0} + 17'({b2, 4'b0})
                    + 17'({b3, 7'b0}) + 17'({b3, 3'b0})
                    + (req_tdata[63] ? NEG_ADJ : 17'd0);

   always_comb begin
      logic [16:0] t;
      t = s1_sum_ff;
      for (int j = 8; j >= 4; j--) begin
         if (t >= (17'(TURN_DEG) << j)) begin
            t = t - (17'(TURN_DEG) << j);
         end
      end
      s2_sum_in = t[12:0];
   end

   always_comb begin
      logic [12:0] t;
      t = s2_sum_ff;
      for (int j = 3; j >= 0; j--) begin
         if (t >= (13'(TURN_DEG) << j)) begin
            t = t - (13'(TURN_DEG) << j);
         end
      end
      s3_deg_in = t[8:0];
   end

   assign cos_sum  = {1'b0, s3_deg_ff} + (s3_func_ff ? 10'(QUARTER_DEG) : 10'd0);
   assign turn_deg = (cos_sum >= 10'(TURN_DEG)) ? 9'(cos_sum - 10'(TURN_DEG))
                                                : cos_sum[8:0];

   dsct_fold u_fold (
      .deg    (turn_deg),
      .frac   (s3_frac_ff),
      .folded (s4_fold_in)
   );

   assign s5_y0_in  = sine_word(s4_fold_ff.deg);
   assign y1_word   = (s4_fold_ff.deg < LAST_DEG) ? sine_word(s4_fold_ff.deg + 7'd1)
                                                  : s5_y0_in;
   assign diff_full = y1_word - s5_y0_in;
   // neighbouring entries differ by less than 2^27
   assign s5_diff_in = diff_full[DIFF_W-1:0];

   assign product    = s5_diff_ff * s5_frac_ff;
   assign s6_step_in = product[DIFF_W+FRAC_W-1:FRAC_W];

   assign mag         = {1'b0, s6_y0_ff} + VALUE_W'(s6_step_ff);
   assign s7_value_in = s6_neg_ff ? (VALUE_W'(0) - mag) : mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_sum_ff  <= s1_sum_in;
         s1_frac_ff <= req_tdata[31:0];
         s1_func_ff <= req_tuser;
      end
      if (stage_en[2]) begin
         s2_sum_ff  <= s2_sum_in;
         s2_frac_ff <= s1_frac_ff;
         s2_func_ff <= s1_func_ff;
      end
      if (stage_en[3]) begin
         s3_deg_ff  <= s3_deg_in;
         s3_frac_ff <= s2_frac_ff;
         s3_func_ff <= s2_func_ff;
      end
      if (stage_en[4]) begin
         s4_fold_ff <= s4_fold_in;
      end
      if (stage_en[5]) begin
         s5_y0_ff   <= s5_y0_in;
         s5_diff_ff <= s5_diff_in;
         s5_frac_ff <= s4_fold_ff.frac;
         s5_neg_ff  <= s4_fold_ff.neg;
      end
      if (stage_en[6]) begin
         s6_step_ff <= s6_step_in;
         s6_y0_ff   <= s5_y0_ff;
         s6_neg_ff  <= s5_neg_ff;
      end
      if (stage_en[7]) begin
         s7_value_ff <= s7_value_in;
      end
   end

   assign rsp_tvalid = valid_ff[STAGES];
   assign rsp_tdata  = {6'b0, s7_value_ff};

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam longint DEG        = 64'sd1 <<< 32;
   localparam longint FULL_TURN  = 64'sd360 <<< 32;
   localparam longint QUARTER    = 64'sd90 <<< 32;
   localparam int     STALL_PCT  = 16;
   localparam int     IDLE_LIMIT = 2000;
   localparam int     TAIL_WAIT  = 20;

   typedef struct {
      logic        func;       // 0 sine, 1 cosine
      logic [63:0] angle;
      bit          drain;      // hold off until every result is back
   } angle_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // angle[63:0]
   logic        req_tuser = 1'b0; // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // value[33:0], zero[39:34]

   angle_request_type pending_angles[$];
   logic [33:0]       expected_values[$];
   int                req_issued = 0;
   int                req_accepted = 0;
   int                results_seen = 0;
   int                error_count = 0;
   int                idle_cycles = 0;

   // whole-degree sine words scaled by 2^32
   longint unsigned sine_words [0:90] = '{
      64'd0, 64'd74957514, 64'd149892196, 64'd224781220,
      64'd299601773, 64'd374331064, 64'd448946331, 64'd523424844,
      64'd597743917, 64'd671880911, 64'd745813244, 64'd819518394,
      64'd892973912, 64'd966157421, 64'd1039046629, 64'd1111619334,
      64'd1183853428, 64'd1255726910, 64'd1327217884, 64'd1398304576,
      64'd1468965330, 64'd1539178623, 64'd1608923067, 64'd1678177418,
      64'd1746920580, 64'd1815131612, 64'd1882789738, 64'd1949874349,
      64'd2016365008, 64'd2082241463, 64'd2147483647, 64'd2212071687,
      64'd2275985909, 64'd2339206843, 64'd2401715232, 64'd2463492035,
      64'd2524518435, 64'd2584775842, 64'd2644245901, 64'd2702910498,
      64'd2760751761, 64'd2817752073, 64'd2873894071, 64'd2929160652,
      64'd2983534983, 64'd3037000499, 64'd3089540917, 64'd3141140230,
      64'd3191782721, 64'd3241452965, 64'd3290135830, 64'd3337816488,
      64'd3384480415, 64'd3430113397, 64'd3474701532, 64'd3518231240,
      64'd3560689261, 64'd3602062661, 64'd3642338838, 64'd3681505523,
      64'd3719550786, 64'd3756463038, 64'd3792231035, 64'd3826843881,
      64'd3860291034, 64'd3892562305, 64'd3923647863, 64'd3953538241,
      64'd3982224332, 64'd4009697399, 64'd4035949074, 64'd4060971359,
      64'd4084756634, 64'd4107297651, 64'd4128587546, 64'd4148619834,
      64'd4167388411, 64'd4184887562, 64'd4201111955, 64'd4216056649,
      64'd4229717092, 64'd4242089121, 64'd4253168969, 64'd4262953261,
      64'd4271439015, 64'd4278623648, 64'd4284504971, 64'd4289081192,
      64'd4292350917, 64'd4294313151, 64'd4294967296
   };

   degree_sine_cosine_table_interp i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic logic [33:0] sine_cosine_of(input logic func, input logic [63:0] angle);
      longint          turn;
      longint unsigned ang;
      longint unsigned whole;
      longint unsigned frac;
      longint unsigned lo_word;
      longint unsigned hi_word;
      longint unsigned mag;
      longint unsigned res;
      bit              neg;
      neg  = 1'b0;
      turn = $signed(angle) % FULL_TURN;
      if (turn < 0) begin
         turn += FULL_TURN;
      end
      ang = turn;
      // cosine offset after reduction, so it wraps at most once
      if (func) begin
         ang += QUARTER;
         if (ang >= FULL_TURN) begin
            ang -= FULL_TURN;
         end
      end
      whole = ang >> 32;
      frac  = ang & 64'hFFFF_FFFF;
      if (whole >= 270) begin
         neg   = 1'b1;
         whole = 360 - whole;
         if (frac != 0) begin
            whole -= 1;
            frac   = DEG - frac;
         end
      end else if (whole >= 180) begin
         neg   = 1'b1;
         whole = whole - 180;
      end else if (whole >= 90) begin
         whole = 180 - whole;
         if (frac != 0) begin
            whole -= 1;
            frac   = DEG - frac;
         end
      end
      if (whole > 90) begin
         whole = 90;
      end
      lo_word = sine_words[whole];
      hi_word = (whole < 90) ? sine_words[whole + 1] : lo_word;
      mag = lo_word + (((hi_word - lo_word) * frac) >> 32);
      res = neg ? (64'd0 - mag) : mag;
      return res[33:0];
   endfunction

   task automatic add_request(input logic func, input logic [63:0] angle, input bit drain);
      angle_request_type item;
      item.func  = func;
      item.angle = angle;
      item.drain = drain;
      pending_angles.push_back(item);
   endtask

   // driver: present the next angle once the current word has gone, and drop rsp_tready at random
   always @(negedge clock) begin
      bit gap;
      bit hold;
      gap  = ($urandom_range(0, 99) < STALL_PCT) && !(req_issued >= 600 && req_issued < 900);
      rsp_tready <= !(($urandom_range(0, 99) < STALL_PCT)
                      && !(results_seen >= 1000 && results_seen < 1300));
      if (!reset && (!req_tvalid || req_accepted == req_issued)) begin
         hold = pending_angles.size() > 0 && pending_angles[0].drain
                && expected_values.size() != 0;
         if (pending_angles.size() > 0 && !gap && !hold) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_angles[0].func;
            req_tdata  <= pending_angles[0].angle;
            void'(pending_angles.pop_front());
            req_issued++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: predict on acceptance, compare results in order
   always @(posedge clock) begin
      logic [33:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_values.push_back(sine_cosine_of(req_tuser, req_tdata));
            req_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_values.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result word, actual %h", $time, rsp_tdata);
            end else begin
               want = expected_values.pop_front();
               if (rsp_tdata !== {6'd0, want}) begin
                  error_count++;
                  $display("%0t: value mismatch, expected %h actual %h",
                           $time, {6'd0, want}, rsp_tdata);
               end
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      int          total_items;
      int          kind;
      longint      whole;
      logic [31:0] frac;
      logic [31:0] hi;
      bit          drain;

      // quadrant edges, mirrored fractions and sign handling
      add_request(1'b0, 64'd0, 1'b0);
      add_request(1'b0, 90 * DEG, 1'b0);
      add_request(1'b1, 64'd0, 1'b0);
      add_request(1'b0, 180 * DEG, 1'b0);
      add_request(1'b0, 270 * DEG, 1'b0);
      add_request(1'b0, 360 * DEG, 1'b0);
      add_request(1'b0, -90 * DEG, 1'b0);
      add_request(1'b1, -90 * DEG, 1'b0);
      add_request(1'b0, -360 * DEG, 1'b0);
      add_request(1'b0, 45 * DEG + 64'h8000_0000, 1'b0);
      add_request(1'b0, 135 * DEG + 64'h4000_0000, 1'b0);
      add_request(1'b0, 225 * DEG + 64'hC000_0000, 1'b0);
      add_request(1'b0, 315 * DEG + 64'h8000_0000, 1'b0);
      add_request(1'b1, 300 * DEG + 64'h8000_0000, 1'b0);
      add_request(1'b1, 270 * DEG, 1'b0);
      add_request(1'b1, 359 * DEG + 64'hFFFF_FFFF, 1'b0);
      add_request(1'b0, 89 * DEG + 64'hFFFF_FFFF, 1'b0);
      add_request(1'b0, 90 * DEG + 1, 1'b0);
      add_request(1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      add_request(1'b0, 64'h8000_0000_0000_0000, 1'b0);
      add_request(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      add_request(1'b1, 64'h8000_0000_0000_0000, 1'b0);
      add_request(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      add_request(1'b0, 64'd1, 1'b0);

      for (int n = 0; n < 1700; n++) begin
         kind  = $urandom_range(0, 99);
         frac  = $urandom;
         drain = (n == 300 || n == 1200);
         if (kind < 40) begin
            whole = longint'($urandom_range(0, 1440)) - 720;
            add_request(1'($urandom_range(0, 1)), {whole[31:0], frac}, drain);
         end else if (kind < 55) begin
            // whole degrees and near-whole, around the folds
            whole = longint'($urandom_range(0, 359)) + 360 * (longint'($urandom_range(0, 20)) - 10);
            case ($urandom_range(0, 2))
               0: frac = 32'd0;
               1: frac = 32'd1;
               default: frac = 32'hFFFF_FFFF;
            endcase
            add_request(1'($urandom_range(0, 1)), {whole[31:0], frac}, drain);
         end else if (kind < 85) begin
            add_request(1'($urandom_range(0, 1)), {$urandom, frac}, drain);
         end else begin
            hi = $urandom_range(0, 1) ? (32'h7FFF_FFFF - $urandom_range(0, 255))
                                      : (32'h8000_0000 + $urandom_range(0, 255));
            add_request(1'($urandom_range(0, 1)), {hi, frac}, drain);
         end
      end
      total_items = pending_angles.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_accepted < total_items || expected_values.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/dsct_pkg.sv
hdl/dsct_fold.sv
hdl/degree_sine_cosine_table_interp.sv
verif/tb.sv
